// ===== design/tsp_pkg.sv =====
// Shared types and constants for the tone sequence PWM player.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tsp_pkg;

	// default table size
	localparam int TSP_TABLE_DEPTH = 64;

	// field widths
	localparam int TSP_ACTION_W = 3;
	localparam int TSP_INDEX_W  = 6;
	localparam int TSP_FREQ_W   = 16;
	localparam int TSP_DUR_W    = 16;
	localparam int TSP_CLK_W    = 27;
	localparam int TSP_PSC_W    = 16;
	localparam int TSP_PER_W    = 16;
	localparam int TSP_TICKS_W  = 23;

	// valid tone frequencies fit in 13 bits
	localparam int TSP_TONE_W   = 13;
	localparam int TSP_DVSR_W   = TSP_TONE_W + TSP_PSC_W;
	localparam int TSP_CNT_W    = 5;

	// stream widths, padded to whole bytes
	localparam int TSP_IN_TDATA_W  = 48;
	localparam int TSP_OUT_TDATA_W = 40;

	// tone limits and silence rate
	localparam logic [TSP_FREQ_W-1:0] TSP_MIN_HZ     = 16'd100;
	localparam logic [TSP_FREQ_W-1:0] TSP_MAX_HZ     = 16'd8000;
	localparam logic [TSP_TONE_W-1:0] TSP_SILENCE_HZ = 13'd100;

	// frequency / 100 as multiply by reciprocal, exact for 0..8191
	localparam logic [TSP_TONE_W-1:0] TSP_DIV100_MUL   = 13'd5243;
	localparam int                    TSP_DIV100_SHIFT = 19;
	localparam int                    TSP_HUND_W       = 7;

	// configuration register indexes
	localparam logic REG_CLOCK_HZ = 1'b0;
	localparam logic REG_PRESCALE = 1'b1;

	// action codes
	typedef enum logic [TSP_ACTION_W-1:0] {
		ACT_TICK = 3'd0,
		ACT_LOAD = 3'd1,
		ACT_PLAY = 3'd2,
		ACT_BEEP = 3'd3,
		ACT_STOP = 3'd4
	} tsp_action_t;

	// request to the period divider
	typedef struct packed {
		logic                  start;
		logic [TSP_TONE_W-1:0] freq;
		logic [TSP_PSC_W-1:0]  scale;
	} tsp_div_req_t;

endpackage

// ===== design/tsp_tone_mem.sv =====
// Tone table: one write port, one registered read port.
// Depends on tsp_pkg for field widths.
`timescale 1ns / 1ps

module tsp_tone_mem
	import tsp_pkg::*;
#(
	parameter int TABLE_DEPTH = TSP_TABLE_DEPTH,
	localparam int ADDR_W = $clog2(TABLE_DEPTH),
	localparam int ENTRY_W = TSP_FREQ_W + TSP_DUR_W
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  logic [ENTRY_W-1:0] wr_data,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	output logic [ENTRY_W-1:0] rd_data
);

	logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/tsp_period_div.sv =====
// Iterative period divider: clock_hz / (freq * prescale), one quotient bit per cycle.
// Depends on tsp_pkg for widths and the request struct.
`timescale 1ns / 1ps

module tsp_period_div
	import tsp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  tsp_div_req_t         req,
	input  logic [TSP_CLK_W-1:0] dividend,
	output logic                 done,
	output logic [TSP_CLK_W-1:0] quotient
);

	logic                  busy_q;
	logic                  done_q;
	logic [TSP_CNT_W-1:0]  cnt_q;
	logic [TSP_DVSR_W-1:0] dvsr_q;
	logic [TSP_DVSR_W-1:0] rem_q;
	logic [TSP_CLK_W-1:0]  quo_q;
	logic [TSP_DVSR_W:0]   shifted;
	logic                  fits;

	// trial subtraction of one step
	always_comb begin
		shifted = {rem_q, quo_q[TSP_CLK_W-1]};
		fits    = (shifted >= {1'b0, dvsr_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= TSP_CNT_W'(TSP_CLK_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == TSP_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: divisor product registered before the first step
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvsr_q <= req.freq * req.scale;
			rem_q  <= '0;
			quo_q  <= dividend;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= TSP_DVSR_W'(shifted - {1'b0, dvsr_q});
			end else begin
				rem_q <= shifted[TSP_DVSR_W-1:0];
			end
			quo_q <= {quo_q[TSP_CLK_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== design/tone_sequence_pwm_player_top.sv =====
// Top level of the tone sequence PWM player: action sequencer and stream ports.
// Depends on tsp_pkg, tsp_tone_mem and tsp_period_div.
`timescale 1ns / 1ps

// Buzzer tone player. Each input item is one action (tick, load table entry, play
// sequence, single beep, stop) and yields exactly one result item with the current
// PWM period, compare, output enable and sequence flag. Tone entries live in a
// single-port-read synchronous table. Stop, load, unused codes and ticks that do not
// step a sequence go straight to the result state; a beep first checks its tone; a
// sequence step or start reads the table entry, then acts on an end marker, a
// silent entry or a tone entry, and a tone entry is checked like a beep. A valid
// tone or silence runs the period divider, which produces one quotient bit per
// cycle over the 27-bit clock value; a silent entry starts the divide as soon as
// the entry is seen, a tone entry only after its check. The next item is accepted
// once the result has been placed in the output register; a result still waiting
// there holds the item in its last cycle until the receiver takes it.

module tone_sequence_pwm_player_top
	import tsp_pkg::*;
#(
	parameter int TABLE_DEPTH = TSP_TABLE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_we,
	input  logic                       cfg_addr,
	input  logic [TSP_CLK_W-1:0]       cfg_wdata,
	// input items
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// action[2:0], tone_index[8:3], frequency[24:9], duration[40:25], zero pad
	input  logic [TSP_IN_TDATA_W-1:0]  s_axis_tdata,
	// result items
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// pwm_period[15:0], pwm_compare[31:16], output_on[32], playing[33], zero pad
	output logic [TSP_OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int ADDR_W  = $clog2(TABLE_DEPTH);
	localparam int ENTRY_W = TSP_FREQ_W + TSP_DUR_W;
	localparam int IDX_N   = 2 ** TSP_INDEX_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ENTRY,
		ST_TONE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [TSP_CLK_W-1:0] clock_hz_q;
	logic [TSP_PSC_W-1:0] prescale_q;

	// player state
	logic [ADDR_W-1:0]      pos_q;
	logic [TSP_TICKS_W-1:0] rem_ticks_q;
	logic                   seq_q;
	logic                   drive_q;
	logic [TSP_PER_W-1:0]   period_q;
	logic [TSP_PER_W-1:0]   compare_q;

	// tone in flight
	logic [TSP_FREQ_W-1:0]            f_q;
	logic [TSP_DUR_W-1:0]             d_q;
	logic                             silence_q;
	logic [TSP_TONE_W+TSP_TONE_W-1:0] recip_q;
	logic [TSP_TICKS_W-1:0]           ticks_q;

	// output register
	logic                       m_valid_q;
	logic [TSP_OUT_TDATA_W-1:0] m_data_q;

	// input fields
	logic [TSP_ACTION_W-1:0] in_action;
	logic [TSP_INDEX_W-1:0]  in_index;
	logic [TSP_FREQ_W-1:0]   in_freq;
	logic [TSP_DUR_W-1:0]    in_dur;
	logic                    accept;
	logic [ADDR_W-1:0]       widx;

	// memory and divider hookup
	logic               mem_we;
	logic [ENTRY_W-1:0] rd_data;
	logic [TSP_FREQ_W-1:0] ent_f;
	logic [TSP_DUR_W-1:0]  ent_d;
	tsp_div_req_t          div_req;
	logic                  div_done;
	logic [TSP_CLK_W-1:0]  div_quo;

	// derived values
	logic [TSP_TICKS_W-1:0] rem_dec;
	logic [ADDR_W-1:0]      pos_next;
	logic                   tone_ok;
	logic [TSP_CLK_W-1:0]   quo_m1;
	logic [TSP_PER_W-1:0]   period_sat;
	logic [TSP_HUND_W-1:0]  hundreds;

	// unpack input item
	assign in_action = s_axis_tdata[2:0];
	assign in_index  = s_axis_tdata[8:3];
	assign in_freq   = s_axis_tdata[24:9];
	assign in_dur    = s_axis_tdata[40:25];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// table index modulo depth, as a constant lookup over all index codes
	always_comb begin
		widx = '0;
		for (int k = 0; k < IDX_N; k++) begin
			if (in_index == TSP_INDEX_W'(k)) begin
				widx = ADDR_W'(k % TABLE_DEPTH);
			end
		end
	end

	// entry fields from the table
	assign ent_f = rd_data[ENTRY_W-1:TSP_DUR_W];
	assign ent_d = rd_data[TSP_DUR_W-1:0];

	// misc combinational helpers
	always_comb begin
		rem_dec  = (rem_ticks_q != '0) ? rem_ticks_q - 1'b1 : '0;
		pos_next = (pos_q == ADDR_W'(TABLE_DEPTH - 1)) ? '0 : pos_q + 1'b1;
		tone_ok  = (f_q >= TSP_MIN_HZ) && (f_q <= TSP_MAX_HZ) && (d_q != '0);
		hundreds = recip_q[TSP_DIV100_SHIFT +: TSP_HUND_W];
		quo_m1   = div_quo - 1'b1;
		if (div_quo == '0) begin
			period_sat = '0;
		end else if (|quo_m1[TSP_CLK_W-1:TSP_PER_W]) begin
			period_sat = '1;
		end else begin
			period_sat = quo_m1[TSP_PER_W-1:0];
		end
	end

	// divider request: silence period on a silent entry, else the tone in flight
	always_comb begin
		div_req.start = 1'b0;
		div_req.freq  = f_q[TSP_TONE_W-1:0];
		div_req.scale = (prescale_q == '0) ? TSP_PSC_W'(1) : prescale_q;
		if (state_q == ST_ENTRY && ent_f == '0 && ent_d != '0) begin
			div_req.start = 1'b1;
			div_req.freq  = TSP_SILENCE_HZ;
		end else if (state_q == ST_TONE && tone_ok) begin
			div_req.start = 1'b1;
		end
	end

	assign mem_we = accept && (in_action == ACT_LOAD);

	tsp_tone_mem #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (widx),
		.wr_data ({in_freq, in_dur}),
		.rd_en   (state_q == ST_READ),
		.rd_addr (pos_q),
		.rd_data (rd_data)
	);

	tsp_period_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (clock_hz_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= TSP_CLK_W'(32000000);
			prescale_q <= TSP_PSC_W'(8);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_CLOCK_HZ: clock_hz_q <= cfg_wdata;
				REG_PRESCALE: prescale_q <= cfg_wdata[TSP_PSC_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, player state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			rem_ticks_q <= '0;
			seq_q       <= 1'b0;
			drive_q     <= 1'b0;
			period_q    <= TSP_PER_W'(999);
			compare_q   <= TSP_PER_W'(499);
			m_valid_q   <= 1'b0;
			m_data_q    <= '0;
		end else begin
			// a result taken while no new one is placed
			if (m_valid_q && m_axis_tready && state_q != ST_DONE) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DONE;
						case (in_action)
							ACT_TICK: begin
								if (drive_q) begin
									rem_ticks_q <= rem_dec;
									if (rem_dec == '0) begin
										if (seq_q) begin
											pos_q   <= pos_next;
											state_q <= ST_READ;
										end else begin
											drive_q <= 1'b0;
										end
									end
								end
							end
							ACT_PLAY: begin
								pos_q   <= widx;
								seq_q   <= 1'b1;
								state_q <= ST_READ;
							end
							ACT_BEEP: begin
								state_q <= ST_TONE;
							end
							ACT_STOP: begin
								drive_q     <= 1'b0;
								seq_q       <= 1'b0;
								rem_ticks_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_ENTRY;
				end
				ST_ENTRY: begin
					// end marker, silence, or a tone to check
					if (ent_f == '0 && ent_d == '0) begin
						drive_q <= 1'b0;
						seq_q   <= 1'b0;
						state_q <= ST_DONE;
					end else if (ent_f == '0) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_TONE;
					end
				end
				ST_TONE: begin
					if (tone_ok) begin
						state_q <= ST_DIV;
					end else begin
						drive_q <= 1'b0;
						seq_q   <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						period_q    <= period_sat;
						compare_q   <= silence_q ? '0 : (period_sat >> 1);
						rem_ticks_q <= ticks_q;
						drive_q     <= 1'b1;
						state_q     <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {6'd0, seq_q, drive_q, compare_q, period_q};
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// tone operands and tick count
	always_ff @(posedge clk) begin
		if (accept) begin
			f_q <= in_freq;
			d_q <= in_dur;
		end
		if (state_q == ST_ENTRY) begin
			f_q       <= ent_f;
			d_q       <= ent_d;
			silence_q <= (ent_f == '0);
			ticks_q   <= TSP_TICKS_W'(ent_d) + 1'b1;
		end
		if (state_q == ST_TONE) begin
			silence_q <= 1'b0;
			recip_q   <= f_q[TSP_TONE_W-1:0] * TSP_DIV100_MUL;
		end
		if (state_q == ST_DIV && !silence_q) begin
			ticks_q <= TSP_TICKS_W'(hundreds) * TSP_TICKS_W'(d_q) + 1'b1;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the tone sequence PWM player top level.
// Depends on tsp_pkg and tone_sequence_pwm_player_top; predicts every result item itself.
`timescale 1ns / 1ps

module tb_top;
	import tsp_pkg::*;

	// action codes the block leaves without effect
	localparam logic [TSP_ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [TSP_ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

	localparam int ITEM_TARGET = 1200;
	localparam int PHASES      = 5;
	localparam int DEPTH       = TSP_TABLE_DEPTH;

	typedef struct packed {
		logic [TSP_PER_W-1:0] period;
		logic [TSP_PER_W-1:0] compare;
		logic                 on;
		logic                 playing;
	} pwm_result_t;

	// tracks the player state and holds the expected pwm results in order
	class pwm_scoreboard;
		logic [TSP_CLK_W-1:0]   clock_hz;
		logic [TSP_PSC_W-1:0]   prescale;
		logic [TSP_FREQ_W-1:0]  tone_freq [DEPTH];
		logic [TSP_DUR_W-1:0]   tone_dur [DEPTH];
		logic [TSP_INDEX_W-1:0] position;
		logic [TSP_TICKS_W-1:0] ticks_left;
		logic                   seq_active;
		logic                   drive_en;
		logic [TSP_PER_W-1:0]   period;
		logic [TSP_PER_W-1:0]   compare;
		pwm_result_t            expected_q[$];
		int                     errors;
		int                     checked;

		function new();
			clock_hz   = 27'd32000000;
			prescale   = 16'd8;
			position   = '0;
			ticks_left = '0;
			seq_active = 1'b0;
			drive_en   = 1'b0;
			period     = 16'd999;
			compare    = 16'd499;
			errors     = 0;
			checked    = 0;
			foreach (tone_freq[i]) begin
				tone_freq[i] = '0;
				tone_dur[i]  = '0;
			end
		endfunction

		function void set_reg(logic addr, logic [TSP_CLK_W-1:0] value);
			if (addr == REG_CLOCK_HZ)
				clock_hz = value;
			else
				prescale = value[TSP_PSC_W-1:0];
		endfunction

		// timer reload for a frequency, clamped to the 16-bit range
		function logic [TSP_PER_W-1:0] period_for(int unsigned hz);
			longint unsigned scale;
			longint unsigned quot;
			scale = (prescale == '0) ? 1 : longint'(prescale);
			quot = longint'(clock_hz) / (longint'(hz) * scale);
			if (quot == 0)
				return '0;
			quot = quot - 1;
			if (quot > 65535)
				quot = 65535;
			return quot[TSP_PER_W-1:0];
		endfunction

		function void halt();
			drive_en   = 1'b0;
			seq_active = 1'b0;
		endfunction

		// a sounding tone; out-of-range frequency or zero length stops everything
		function void begin_tone(logic [TSP_FREQ_W-1:0] hz, logic [TSP_DUR_W-1:0] dur);
			int unsigned span;
			if (hz < TSP_MIN_HZ || hz > TSP_MAX_HZ || dur == '0) begin
				halt();
				return;
			end
			span       = (int'(hz) / 100) * int'(dur) + 1;
			ticks_left = span[TSP_TICKS_W-1:0];
			period     = period_for(hz);
			compare    = period >> 1;
			drive_en   = 1'b1;
		endfunction

		// act on the entry under the sequence position
		function void fetch_entry();
			logic [TSP_FREQ_W-1:0] hz;
			logic [TSP_DUR_W-1:0]  dur;
			hz  = tone_freq[position];
			dur = tone_dur[position];
			if (hz == '0 && dur == '0) begin
				halt();
			end else if (hz == '0) begin
				period     = period_for(TSP_SILENCE_HZ);
				compare    = '0;
				ticks_left = TSP_TICKS_W'(dur) + 1'b1;
				drive_en   = 1'b1;
			end else begin
				begin_tone(hz, dur);
			end
		endfunction

		function void advance_tick();
			if (!drive_en)
				return;
			if (ticks_left != '0)
				ticks_left = ticks_left - 1'b1;
			if (ticks_left != '0)
				return;
			if (seq_active) begin
				position = position + 1'b1;
				fetch_entry();
			end else begin
				drive_en = 1'b0;
			end
		endfunction

		function void note_item(logic [TSP_IN_TDATA_W-1:0] data);
			logic [TSP_ACTION_W-1:0] act;
			logic [TSP_INDEX_W-1:0]  idx;
			logic [TSP_FREQ_W-1:0]   hz;
			logic [TSP_DUR_W-1:0]    dur;
			pwm_result_t             res;
			act = data[2:0];
			idx = data[8:3];
			hz  = data[24:9];
			dur = data[40:25];
			case (act)
				ACT_TICK: advance_tick();
				ACT_LOAD: begin
					tone_freq[idx] = hz;
					tone_dur[idx]  = dur;
				end
				ACT_PLAY: begin
					position   = idx;
					seq_active = 1'b1;
					fetch_entry();
				end
				ACT_BEEP: begin_tone(hz, dur);
				ACT_STOP: begin
					halt();
					ticks_left = '0;
				end
				default: ;
			endcase
			res.period  = period;
			res.compare = compare;
			res.on      = drive_en;
			res.playing = seq_active;
			expected_q.push_back(res);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want == got)
				return;
			errors++;
			$display("%0t tb mismatch on %s: expected %0d actual %0d", $time, name,
				want, got);
		endfunction

		function void check_result(logic [TSP_OUT_TDATA_W-1:0] tdata);
			pwm_result_t want;
			checked++;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t tb unexpected result: expected none actual %h", $time,
					tdata);
				return;
			end
			want = expected_q.pop_front();
			compare_field("pwm_period", want.period, tdata[15:0]);
			compare_field("pwm_compare", want.compare, tdata[31:16]);
			compare_field("output_on", want.on, tdata[32]);
			compare_field("playing", want.playing, tdata[33]);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic                       cfg_addr = REG_CLOCK_HZ;
	logic [TSP_CLK_W-1:0]       cfg_wdata = '0;
	logic                       s_axis_tvalid = 1'b0;
	logic                       s_axis_tready;
	logic [TSP_IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	logic [TSP_OUT_TDATA_W-1:0] m_axis_tdata;

	pwm_scoreboard sb = new();
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int items_sent = 0;

	always #2 clk = ~clk;

	tone_sequence_pwm_player_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// result side back-pressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// every accepted result goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// hard stop on a hung run
	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [TSP_IN_TDATA_W-1:0] tone_item(logic [TSP_ACTION_W-1:0] act,
			logic [TSP_INDEX_W-1:0] idx, logic [TSP_FREQ_W-1:0] hz,
			logic [TSP_DUR_W-1:0] dur);
		return {7'b0, dur, hz, idx, act};
	endfunction

	// mostly low tones so that sequences step along quickly
	function automatic logic [TSP_FREQ_W-1:0] short_tone_hz();
		if ($urandom_range(99) < 75)
			return TSP_FREQ_W'($urandom_range(499, 100));
		return TSP_FREQ_W'($urandom_range(8000, 100));
	endfunction

	function automatic logic [TSP_IN_TDATA_W-1:0] random_item();
		logic [TSP_FREQ_W-1:0]  boundary_hz [5];
		logic [TSP_DUR_W-1:0]   boundary_dur [3];
		logic [TSP_INDEX_W-1:0] r_idx;
		logic [TSP_FREQ_W-1:0]  r_hz;
		logic [TSP_DUR_W-1:0]   r_dur;
		logic [TSP_DUR_W-1:0]   r_short;
		logic [2:0]             hz_sel;
		logic [1:0]             dur_sel;
		int                     pick;
		int                     kind;
		boundary_hz  = '{16'd99, TSP_MIN_HZ, TSP_MAX_HZ, 16'd8001, 16'd0};
		boundary_dur = '{16'd0, 16'd1, 16'hFFFF};
		pick    = $urandom_range(99);
		kind    = $urandom_range(99);
		r_idx   = TSP_INDEX_W'($urandom);
		r_hz    = TSP_FREQ_W'($urandom);
		r_dur   = TSP_DUR_W'($urandom);
		r_short = TSP_DUR_W'($urandom_range(2, 1));
		hz_sel  = 3'($urandom_range(4));
		dur_sel = 2'($urandom_range(2));
		if (pick < 56)
			return tone_item(ACT_TICK, r_idx, r_hz, r_dur);
		if (pick < 66) begin
			if (kind < 60)
				return tone_item(ACT_LOAD, r_idx, short_tone_hz(), r_short);
			if (kind < 75)
				return tone_item(ACT_LOAD, r_idx, '0, TSP_DUR_W'($urandom_range(3, 1)));
			if (kind < 87)
				return tone_item(ACT_LOAD, r_idx, '0, '0);
			return tone_item(ACT_LOAD, r_idx, r_hz, r_dur);
		end
		if (pick < 76)
			return tone_item(ACT_PLAY, r_idx, r_hz, r_dur);
		if (pick < 88) begin
			if (kind < 60)
				return tone_item(ACT_BEEP, r_idx, short_tone_hz(), r_short);
			if (kind < 80)
				return tone_item(ACT_BEEP, r_idx, r_hz, r_dur);
			return tone_item(ACT_BEEP, r_idx, boundary_hz[hz_sel], boundary_dur[dur_sel]);
		end
		if (pick < 95)
			return tone_item(ACT_STOP, r_idx, r_hz, r_dur);
		return tone_item(TSP_ACTION_W'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST)),
			r_idx, r_hz, r_dur);
	endfunction

	// present one item and hold it until accepted; valid stays high afterwards
	task automatic send_item(input logic [TSP_IN_TDATA_W-1:0] data);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(data);
		items_sent++;
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(input logic [TSP_CLK_W-1:0] hz, input logic [TSP_CLK_W-1:0] psc);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_CLOCK_HZ;
		cfg_wdata <= hz;
		@(posedge clk);
		cfg_addr  <= REG_PRESCALE;
		cfg_wdata <= psc;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(REG_CLOCK_HZ, hz);
		sb.set_reg(REG_PRESCALE, psc);
	endtask

	// every entry gets written before any sequence can read it
	task automatic fill_table();
		for (int i = 0; i < DEPTH; i++) begin
			if (i % 8 == 7)
				send_item(tone_item(ACT_LOAD, TSP_INDEX_W'(i), '0, '0));
			else if (i % 8 == 3)
				send_item(tone_item(ACT_LOAD, TSP_INDEX_W'(i), '0,
					TSP_DUR_W'($urandom_range(3, 1))));
			else
				send_item(tone_item(ACT_LOAD, TSP_INDEX_W'(i), short_tone_hz(),
					TSP_DUR_W'($urandom_range(2, 1))));
		end
	endtask

	task automatic directed_items();
		// lowest tone runs out after two ticks, then a tick while off
		send_item(tone_item(ACT_BEEP, '0, TSP_MIN_HZ, 16'd1));
		repeat (3) send_item(tone_item(ACT_TICK, '0, '0, '0));
		// highest tone, then tones just outside the range and a zero length
		send_item(tone_item(ACT_BEEP, '0, TSP_MAX_HZ, 16'd1));
		send_item(tone_item(ACT_BEEP, '0, 16'd99, 16'd1));
		send_item(tone_item(ACT_BEEP, '0, 16'd8001, 16'd1));
		send_item(tone_item(ACT_BEEP, '0, 16'd1000, 16'd0));
		// longest tone cut short by stop
		send_item(tone_item(ACT_BEEP, '0, TSP_MAX_HZ, 16'hFFFF));
		send_item(tone_item(ACT_STOP, '0, '0, '0));
		// unused codes with all field bits set
		for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
			send_item(tone_item(TSP_ACTION_W'(a), '1, '1, '1));
		// sequence opening with silence just below the top entry, wrapping to a terminator
		send_item(tone_item(ACT_LOAD, 6'd62, '0, 16'd1));
		send_item(tone_item(ACT_LOAD, 6'd63, 16'd150, 16'd1));
		send_item(tone_item(ACT_LOAD, 6'd0, '0, '0));
		send_item(tone_item(ACT_PLAY, 6'd62, '0, '0));
		repeat (4) send_item(tone_item(ACT_TICK, '0, '0, '0));
		// starting on a terminator stops at once
		send_item(tone_item(ACT_PLAY, 6'd0, '0, '0));
		// beep inside a sequence, then the sequence resumes at the next entry
		send_item(tone_item(ACT_PLAY, 6'd62, '0, '0));
		send_item(tone_item(ACT_BEEP, '0, 16'd200, 16'd1));
		repeat (3) send_item(tone_item(ACT_TICK, '0, '0, '0));
		// out-of-range beep stops the running sequence
		send_item(tone_item(ACT_BEEP, '0, 16'hFFFF, 16'hFFFF));
		// out-of-range entry stops a sequence on its first step
		send_item(tone_item(ACT_LOAD, 6'd5, 16'hFFFF, 16'hFFFF));
		send_item(tone_item(ACT_PLAY, 6'd5, '0, '0));
	endtask

	initial begin
		logic [TSP_CLK_W-1:0]      phase_hz [PHASES];
		logic [TSP_CLK_W-1:0]      phase_psc [PHASES];
		int                        tx_mode [4];
		int                        rx_mode [4];
		int                        counted;
		logic [TSP_IN_TDATA_W-1:0] item;

		// reset values first, then extremes, a random mix and a zero prescaler
		phase_hz  = '{27'd32000000, 27'd100000000, 27'd1000000,
			TSP_CLK_W'($urandom_range(100000000, 1000000)), 27'd48000000};
		phase_psc = '{27'd8, 27'd1, 27'd65535, TSP_CLK_W'($urandom_range(64, 1)), 27'd0};
		tx_mode = '{0, 66, 0, 25};
		rx_mode = '{0, 0, 66, 25};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		fill_table();
		directed_items();

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				drain();
				write_regs(phase_hz[phase], phase_psc[phase]);
			end
			tx_idle_pct  = tx_mode[phase % 4];
			rx_stall_pct = rx_mode[phase % 4];
			counted = 0;
			while (counted < ITEM_TARGET / PHASES) begin
				item = random_item();
				counted++;
				send_item(item);
			end
		end

		drain();
		repeat (40) @(posedge clk);

		$display("tb: %0d items sent over %0d register settings and four idle patterns,",
			items_sent, PHASES);
		$display("tb: %0d results checked, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/tsp_pkg.sv
design/tsp_tone_mem.sv
design/tsp_period_div.sv
design/tone_sequence_pwm_player_top.sv
tb/tb_top.sv
